// File: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and character helpers of the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  parameter int unsigned VALUE_BITS_DEF = 32;
  parameter int unsigned OPCODE_W       = 3;
  parameter int unsigned VALUE_W        = 64;
  parameter int unsigned CHAR_W         = 8;
  parameter int unsigned COUNT_W        = 6;
  parameter int unsigned PTR_BITS       = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_BIN  = 3'd2,
    OP_OCT  = 3'd3,
    OP_HEXL = 3'd4,
    OP_HEXU = 3'd5,
    OP_PTR  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREFIX,
    ST_DIGITS
  } state_e;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } prefix_e;

  typedef enum logic [1:0] {
    RDX_BIN,
    RDX_OCT,
    RDX_HEX
  } radix_e;

  function automatic logic [CHAR_W-1:0] prefix_char(prefix_e p, logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    c = "0";
    case (p)
      PFX_MINUS: c = "-";
      PFX_HEX:   c = (idx == 3'd0) ? "0" : "x";
      PFX_NIL: begin
        case (idx)
          3'd0:    c = "(";
          3'd1:    c = "n";
          3'd2:    c = "i";
          3'd3:    c = "l";
          default: c = ")";
        endcase
      end
      default:   c = "0";
    endcase
    return c;
  endfunction

  function automatic logic [2:0] prefix_last_idx(prefix_e p);
    logic [2:0] n;
    case (p)
      PFX_HEX: n = 3'd1;
      PFX_NIL: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'b0, d};
    end else begin
      c = (lower ? 8'h61 : 8'h41) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: design/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels of the formatter: number in, characters out.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  import itoa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_out;
  logic               last;
  logic [COUNT_W-1:0] total_count;

  modport source (output valid, output char_out, output last, output total_count,
                  input ready);
  modport sink   (input valid, input char_out, input last, input total_count,
                  output ready);
endinterface

// File: design/integer_to_ascii_formatter_core.sv
// Decimal modes first run the shift-and-add-3 BCD unit over the VALUE_BITS input bits,
// then walk the BCD digits, emitting characters and skipping leading zero positions.
// Binary, octal and hex walk the digit positions of the shift register directly;
// pointer mode emits "0x" then walks 16 hex positions, or emits "(nil)" for zero.
// A new number is accepted only while idle, after the last character of the previous one.
// Reset clears the sequencer and the output valid; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer per transaction as ASCII text, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itoa_in_if.sink   in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  localparam int unsigned NDEC   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NOCT   = (VALUE_BITS + 2) / 3;
  localparam int unsigned NHEX   = (VALUE_BITS + 3) / 4;
  localparam int unsigned NPTR   = PTR_BITS / 4;
  localparam int unsigned BCD_W  = 4 * NDEC;
  localparam int unsigned W_A    = (BCD_W > 3 * NOCT) ? BCD_W : 3 * NOCT;
  localparam int unsigned W      = (W_A > PTR_BITS) ? W_A : PTR_BITS;
  localparam int unsigned MAXPOS = (VALUE_BITS > NPTR) ? VALUE_BITS : NPTR;
  localparam int unsigned POS_W  = $clog2(MAXPOS + 1);
  localparam int unsigned STEP_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned CNT_RAW = $clog2(VALUE_BITS + 19);
  localparam int unsigned CNT_W  = (CNT_RAW > COUNT_W) ? CNT_RAW : COUNT_W;

  state_e              state_q, state_d;
  prefix_e             prefix_q, prefix_d;
  radix_e              radix_q, radix_d;
  logic [2:0]          pidx_q, pidx_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                started_q, started_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                lower_q, lower_d;
  logic [W-1:0]        sreg_q, sreg_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                last_q, last_d;
  logic [COUNT_W-1:0]  total_q, total_d;

  logic [VALUE_BITS-1:0] v, mag;
  logic                neg, accept, can_emit, is_last_pos, skip;
  logic [BCD_W-1:0]    bcd_adj, bcd_next;
  logic [3:0]          dig;
  logic [W-1:0]        sh;
  logic                emit, emit_last;
  logic [CHAR_W-1:0]   emit_char;
  logic [CNT_W-1:0]    cnt_inc;

  assign v        = in_i.value[VALUE_BITS-1:0];
  assign neg      = v[VALUE_BITS-1];
  assign mag      = ~v + {{(VALUE_BITS-1){1'b0}}, 1'b1};
  assign accept   = in_i.valid && in_i.ready;
  assign can_emit = !out_valid_q || out_o.ready;
  assign cnt_inc  = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    for (int k = 0; k < NDEC; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                      : bcd_q[4*k +: 4];
    end
  end

  assign bcd_next = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};

  always_comb begin
    case (radix_q)
      RDX_BIN: begin
        dig = {3'b0, sreg_q[W-1]};
        sh  = sreg_q << 1;
      end
      RDX_OCT: begin
        dig = {1'b0, sreg_q[W-1 -: 3]};
        sh  = sreg_q << 3;
      end
      RDX_HEX: begin
        dig = sreg_q[W-1 -: 4];
        sh  = sreg_q << 4;
      end
      default: begin
        dig = 4'd0;
        sh  = sreg_q;
      end
    endcase
  end

  assign is_last_pos = (pos_q == POS_W'(1));
  assign skip        = !started_q && (dig == 4'd0) && !is_last_pos;

  always_comb begin
    state_d   = state_q;
    prefix_d  = prefix_q;
    radix_d   = radix_q;
    pidx_d    = pidx_q;
    pos_d     = pos_q;
    started_d = started_q;
    step_d    = step_q;
    lower_d   = lower_q;
    sreg_d    = sreg_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pidx_d    = '0;
          started_d = 1'b0;
          prefix_d  = PFX_NONE;
          lower_d   = (in_i.opcode == OP_HEXL) || (in_i.opcode == OP_PTR);
          case (op_e'(in_i.opcode))
            OP_SDEC, OP_UDEC: begin
              if ((in_i.opcode == OP_SDEC) && neg) begin
                bin_d    = mag;
                prefix_d = PFX_MINUS;
              end else begin
                bin_d = v;
              end
              bcd_d   = '0;
              step_d  = STEP_W'(VALUE_BITS);
              state_d = ST_CONV;
            end
            OP_BIN: begin
              sreg_d  = W'(v) << (W - VALUE_BITS);
              radix_d = RDX_BIN;
              pos_d   = POS_W'(VALUE_BITS);
              state_d = ST_DIGITS;
            end
            OP_OCT: begin
              sreg_d  = W'(v) << (W - 3 * NOCT);
              radix_d = RDX_OCT;
              pos_d   = POS_W'(NOCT);
              state_d = ST_DIGITS;
            end
            OP_HEXL, OP_HEXU: begin
              sreg_d  = W'(v) << (W - 4 * NHEX);
              radix_d = RDX_HEX;
              pos_d   = POS_W'(NHEX);
              state_d = ST_DIGITS;
            end
            OP_PTR: begin
              if (in_i.value == '0) begin
                prefix_d = PFX_NIL;
              end else begin
                prefix_d = PFX_HEX;
                sreg_d   = W'(in_i.value) << (W - PTR_BITS);
                radix_d  = RDX_HEX;
                pos_d    = POS_W'(NPTR);
              end
              state_d = ST_PREFIX;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        bcd_d  = bcd_next;
        bin_d  = bin_q << 1;
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          sreg_d  = W'(bcd_next) << (W - BCD_W);
          radix_d = RDX_HEX;
          pos_d   = POS_W'(NDEC);
          state_d = (prefix_q == PFX_NONE) ? ST_DIGITS : ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = prefix_char(prefix_q, pidx_q);
          pidx_d    = pidx_q + 3'd1;
          if (pidx_q == prefix_last_idx(prefix_q)) begin
            if (prefix_q == PFX_NIL) begin
              emit_last = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              state_d = ST_DIGITS;
            end
          end
        end
      end
      ST_DIGITS: begin
        if (skip) begin
          sreg_d = sh;
          pos_d  = pos_q - POS_W'(1);
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_char = digit_char(dig, lower_q);
          started_d = 1'b1;
          sreg_d    = sh;
          pos_d     = pos_q - POS_W'(1);
          if (is_last_pos) begin
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    total_d     = total_q;
    if (accept) begin
      cnt_d = '0;
    end
    if (emit) begin
      cnt_d       = cnt_inc;
      out_valid_d = 1'b1;
      char_d      = emit_char;
      last_d      = emit_last;
      total_d     = emit_last ? cnt_inc[COUNT_W-1:0] : '0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prefix_q    <= PFX_NONE;
      radix_q     <= RDX_HEX;
      pidx_q      <= '0;
      pos_q       <= '0;
      started_q   <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      radix_q     <= radix_d;
      pidx_q      <= pidx_d;
      pos_q       <= pos_d;
      started_q   <= started_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lower_q <= lower_d;
    sreg_q  <= sreg_d;
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    char_q  <= char_d;
    last_q  <= last_d;
    total_q <= total_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.char_out    = char_q;
  assign out_o.last        = last_q;
  assign out_o.total_count = total_q;

`ifndef ASSERT_OFF
  a_digits_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS) |-> (pos_q != '0))
    else $error("digit walk with no positions left");

  a_conv_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (step_q != '0))
    else $error("BCD conversion with no steps left");

  a_count_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (out_o.total_count == '0))
    else $error("count shown on a character that is not last");

  a_bad_opcode_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.opcode > OP_PTR)) |=> (state_q == ST_IDLE))
    else $error("unused opcode started a transaction");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> ($stable(out_o.char_out) && out_o.valid))
    else $error("stalled character overwritten");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_ascii_formatter_core. A queue-fed driver
// sends numbers with format opcodes over the valid/ready input channel. Each
// accepted transaction is rendered into its expected character stream by an
// independent formatter model. A monitor compares every output character, last
// flag and count in order. Both channels idle in random bursts, with a quiet
// tail at the end of the run.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int unsigned VBITS      = VALUE_BITS_DEF;
  localparam int unsigned N_RANDOM   = 78;
  localparam int unsigned QUIET_TAIL = 25;
  localparam int unsigned DRAIN_CYC  = 100;

  typedef struct {
    op_e         op;
    logic [63:0] value;
  } number_t;

  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } char_beat_t;

  logic clk_i;
  logic rst_ni;

  itoa_in_if  in_if ();
  itoa_out_if out_if ();

  integer_to_ascii_formatter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  number_t    numbers_to_send[$];
  char_beat_t expected_chars[$];

  int unsigned numbers_accepted;
  int unsigned chars_checked;
  int unsigned errors;
  int unsigned per_op[7];
  bit          idling_en;
  int unsigned send_gap;
  int unsigned sink_stall;

  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] digit_to_ascii(logic [3:0] d, bit lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = (lower ? 8'h61 : 8'h41) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  // Appends the character stream of one number to expected_chars.
  function automatic void format_number(op_e op, logic [63:0] raw);
    logic [7:0]  text[80];
    logic [7:0]  digs[64];
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] radix;
    bit          lower;
    bit          with_digits;
    int unsigned len;
    int unsigned nd;
    char_beat_t  beat;
    mask        = {64{1'b1}} >> (64 - VBITS);
    v           = raw & mask;
    len         = 0;
    nd          = 0;
    lower       = 1'b0;
    radix       = 64'd10;
    with_digits = 1'b1;
    case (op)
      OP_SDEC: begin
        if (v[VBITS-1]) begin
          text[len] = "-";
          len++;
          v = (64'd0 - v) & mask;
        end
      end
      OP_UDEC: radix = 64'd10;
      OP_BIN:  radix = 64'd2;
      OP_OCT:  radix = 64'd8;
      OP_HEXL: begin
        radix = 64'd16;
        lower = 1'b1;
      end
      OP_HEXU: radix = 64'd16;
      OP_PTR: begin
        radix = 64'd16;
        lower = 1'b1;
        v     = raw;
        if (raw == 64'd0) begin
          text[0] = "(";
          text[1] = "n";
          text[2] = "i";
          text[3] = "l";
          text[4] = ")";
          len = 5;
          with_digits = 1'b0;
        end else begin
          text[0] = "0";
          text[1] = "x";
          len = 2;
        end
      end
      default: with_digits = 1'b0;
    endcase
    if (with_digits) begin
      do begin
        digs[nd] = digit_to_ascii(4'(v % radix), lower);
        v = v / radix;
        nd++;
      end while (v != 64'd0 && nd < 64);
      for (int i = 0; i < nd; i++) begin
        text[len] = digs[nd - 1 - i];
        len++;
      end
    end
    for (int i = 0; i < len; i++) begin
      beat.ch    = text[i];
      beat.last  = (i + 1 == len);
      beat.count = beat.last ? COUNT_W'(len) : '0;
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0:       v = {$urandom, $urandom};
      1:       v = 64'($urandom_range(0, 20));
      2:       v = 64'd1 << $urandom_range(0, 63);
      3:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
      4:       v = {$urandom, 32'hffff_ffff - 32'($urandom_range(0, 20))};
      5:       v = {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 20))};
      default: v = {$urandom, 32'h7fff_ffff - 32'($urandom_range(0, 20))};
    endcase
    return v;
  endfunction

  function automatic void queue_number(op_e op, logic [63:0] value);
    number_t n;
    n.op    = op;
    n.value = value;
    numbers_to_send.push_back(n);
  endfunction

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= '0;
      in_if.value  <= '0;
      send_gap     <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        format_number(op_e'(in_if.opcode), in_if.value);
        per_op[in_if.opcode]++;
        numbers_accepted++;
      end
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (idling_en && $urandom_range(0, 5) == 0) begin
        send_gap    <= $urandom_range(0, 11);
        in_if.valid <= 1'b0;
      end else if (numbers_to_send.size() > 0) begin
        number_t n;
        n = numbers_to_send.pop_front();
        in_if.valid  <= 1'b1;
        in_if.opcode <= n.op;
        in_if.value  <= n.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char 0x%02h last=%0b count=%0d", $time,
                   out_if.char_out, out_if.last, out_if.total_count);
          errors++;
        end else begin
          char_beat_t e;
          e = expected_chars.pop_front();
          chars_checked++;
          if (out_if.char_out !== e.ch) begin
            $display("%0t: char_out expected 0x%02h actual 0x%02h", $time,
                     e.ch, out_if.char_out);
            errors++;
          end
          if (out_if.last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, out_if.last);
            errors++;
          end
          if (out_if.total_count !== e.count) begin
            $display("%0t: total_count expected %0d actual %0d", $time,
                     e.count, out_if.total_count);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall   <= sink_stall - 1;
        out_if.ready <= 1'b0;
      end else if (idling_en && $urandom_range(0, 7) == 0) begin
        sink_stall   <= $urandom_range(0, 11);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned total;
    in_if.valid      = 1'b0;
    in_if.opcode     = '0;
    in_if.value      = '0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    idling_en        = 1'b1;
    numbers_accepted = 0;
    chars_checked    = 0;
    errors           = 0;
    foreach (per_op[i]) per_op[i] = 0;

    queue_number(OP_SDEC, 64'd0);
    queue_number(OP_SDEC, 64'h0000_0000_7fff_ffff);
    queue_number(OP_SDEC, 64'h0000_0000_8000_0000);
    queue_number(OP_SDEC, 64'hffff_ffff_ffff_ffff);
    queue_number(OP_SDEC, 64'hdead_beef_0000_0005);
    queue_number(OP_UDEC, 64'h0000_0000_ffff_ffff);
    queue_number(OP_UDEC, 64'hffff_ffff_0000_0000);
    queue_number(OP_BIN,  64'd0);
    queue_number(OP_BIN,  64'h0000_0000_ffff_ffff);
    queue_number(OP_BIN,  64'h8000_0000_0000_0001);
    queue_number(OP_OCT,  64'h0000_0000_ffff_ffff);
    queue_number(OP_OCT,  64'd0);
    queue_number(OP_HEXL, 64'h0000_0000_abcd_ef12);
    queue_number(OP_HEXL, 64'hffff_ffff_ffff_ffff);
    queue_number(OP_HEXU, 64'h0000_0000_0bad_cafe);
    queue_number(OP_HEXU, 64'd0);
    queue_number(OP_PTR,  64'd0);
    queue_number(OP_PTR,  64'hffff_ffff_ffff_ffff);
    queue_number(OP_PTR,  64'd1);
    queue_number(OP_PTR,  64'ha000_0000_0000_0000);
    queue_number(OP_PTR,  64'h0000_0001_0000_0000);
    queue_number(OP_PTR,  64'h0123_4567_89ab_cdef);
    for (int i = 0; i < N_RANDOM; i++) begin
      queue_number(op_e'($urandom_range(0, 6)), random_value());
    end
    total = numbers_to_send.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (numbers_accepted >= total - QUIET_TAIL);
    idling_en = 1'b0;
    wait (numbers_accepted == total && expected_chars.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Formatted %0d numbers (sdec %0d, udec %0d, bin %0d, oct %0d, hex %0d/%0d, ptr %0d)",
             numbers_accepted, per_op[OP_SDEC], per_op[OP_UDEC], per_op[OP_BIN],
             per_op[OP_OCT], per_op[OP_HEXL], per_op[OP_HEXU], per_op[OP_PTR]);
    $display("Checked %0d output characters, %0d mismatches", chars_checked, errors);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d characters still expected", $time, expected_chars.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
